@@ rtl/eftl_pkg.sv @@
// Shared types and constants for the event filter trace log.
package eftl_pkg;

  localparam int RULE_SLOTS_DEF = 16;
  localparam int LOG_DEPTH_DEF  = 64;

  // Rule count and delete index travel at a fixed width that covers up to 127 slots
  localparam int RULE_CNT_W = 7;

  typedef enum logic [1:0] {
    KIND_LOG  = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FILT_ANY  = 2'd0,
    FILT_FAIL = 2'd1,
    FILT_PASS = 2'd2,
    FILT_RSVD = 2'd3
  } filt_t;

  localparam logic REG_LOG_EN = 1'b0;

  typedef struct packed {
    logic       enabled;
    logic [7:0] code;
    logic [1:0] filter;
  } rule_t;

  typedef struct packed {
    logic                  add;
    logic                  del;
    logic [RULE_CNT_W-1:0] count;
    logic [RULE_CNT_W-1:0] del_idx;
    rule_t                 new_rule;
    logic [7:0]            ev_code;
    logic                  ev_ok;
  } rule_ctl_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  code;
    logic        ok;
    logic [15:0] pid;
  } rec_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [7:0]  code;
    logic        ok;
    logic [15:0] pid;
  } ring_ctl_t;

endpackage

@@ rtl/eftl_if.sv @@
// Command and response channel interfaces.
interface eftl_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  event_type;
  logic        success;
  logic [15:0] pid;
  logic [7:0]  rule_type;
  logic [1:0]  rule_filter;
  logic        rule_enabled;
  logic [3:0]  rule_index;

  modport source(output valid, kind, event_type, success, pid, rule_type, rule_filter,
                 rule_enabled, rule_index, input ready);
  modport sink(input valid, kind, event_type, success, pid, rule_type, rule_filter,
               rule_enabled, rule_index, output ready);
endinterface

interface eftl_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  rule_slot;
  logic        logged;
  logic [31:0] rec_id;
  logic [31:0] rec_serial;
  logic [7:0]  rec_type;
  logic        rec_success;
  logic [15:0] rec_pid;
  logic [6:0]  record_count;

  modport source(output valid, status, rule_slot, logged, rec_id, rec_serial, rec_type,
                 rec_success, rec_pid, record_count, input ready);
  modport sink(input valid, status, rule_slot, logged, rec_id, rec_serial, rec_type,
               rec_success, rec_pid, record_count, output ready);
endinterface

@@ rtl/eftl_rule_cell.sv @@
// One rule slot: holds a rule, matches events, shifts down on delete.
module eftl_rule_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               commit,
  input  eftl_pkg::rule_ctl_t ctl,
  input  eftl_pkg::rule_t    nbr,
  output eftl_pkg::rule_t    rule,
  output logic               hit
);

  localparam logic [eftl_pkg::RULE_CNT_W-1:0] MY_IDX = eftl_pkg::RULE_CNT_W'(IDX);

  logic live;
  logic code_ok;
  logic filt_ok;

  assign live    = MY_IDX < ctl.count;
  assign code_ok = (rule.code == 8'd0) || (rule.code == ctl.ev_code);

  always_comb begin
    case (eftl_pkg::filt_t'(rule.filter))
      eftl_pkg::FILT_FAIL: filt_ok = !ctl.ev_ok;
      eftl_pkg::FILT_PASS: filt_ok = ctl.ev_ok;
      default:             filt_ok = 1'b1;
    endcase
  end

  assign hit = live && rule.enabled && code_ok && filt_ok;

  // delete: every slot at or above the hole takes its upper neighbor
  always_ff @(posedge clk) begin
    if (commit) begin
      if (ctl.add && (MY_IDX == ctl.count)) begin
        rule <= ctl.new_rule;
      end else if (ctl.del && (MY_IDX >= ctl.del_idx)) begin
        rule <= nbr;
      end
    end
  end

endmodule

@@ rtl/eftl_log_ring.sv @@
// Ring log of records with overwrite-oldest, running id and registered read.
module eftl_log_ring #(
  parameter int LOG_DEPTH = eftl_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  eftl_pkg::ring_ctl_t            ctl,
  output eftl_pkg::rec_t                 rd_rec,
  output logic                           empty,
  output logic [$clog2(LOG_DEPTH+1)-1:0] count_next
);

  localparam int PW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(LOG_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(LOG_DEPTH);

  eftl_pkg::rec_t mem [LOG_DEPTH];

  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [31:0]   next_id;
  logic          full;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;

  assign full     = count == FULL;
  assign empty    = count == '0;
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;

  always_comb begin
    count_next = count;
    if (ctl.push && !full) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_rec <= mem[head];
    if (ctl.push) begin
      mem[tail] <= '{id: next_id, code: ctl.code, ok: ctl.ok, pid: ctl.pid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      next_id <= '0;
    end else begin
      count <= count_next;
      if (ctl.push) begin
        tail    <= tail_inc;
        next_id <= next_id + 32'd1;
        if (full) begin
          head <= head_inc;
        end
      end else if (ctl.pop) begin
        head <= head_inc;
      end
    end
  end

endmodule

@@ rtl/event_filter_trace_log_unit.sv @@
// Event filter trace log: top level with command sequencer and config port.
//
// Usage: commands enter on the cmd channel (valid/ready). kind selects log
// event, add rule, delete rule or read oldest record. Every command gives
// exactly one response word on the rsp channel.
// Timing: a command is taken in the idle cycle, executed in the next one and
// its response is registered at the end of that cycle. A new command is only
// taken after the last one has executed; the idle cycle holds the registered
// read of the log memory at the head pointer, which the execute cycle consumes.
// Rules sit in a row of cells; each compares its own rule against the event,
// and on delete every cell above the hole copies its upper neighbor.
// The log is a ring memory; a full log drops its oldest record on a new one.
// Stall: the response register holds its word until taken. A new command is
// still taken while a word waits; its execute cycle then waits until the
// response register is free.
// Reset (synchronous, rst high): rule count, log pointers, record count and
// running id go to zero and logging is enabled. Rule and log storage are not
// cleared; only written entries are ever read.
// Config: one APB register at address 0, bit 0 = logging enable.
module event_filter_trace_log_unit #(
  parameter int RULE_SLOTS = eftl_pkg::RULE_SLOTS_DEF,
  parameter int LOG_DEPTH  = eftl_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  eftl_cmd_if.sink    cmd,
  eftl_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RCW = eftl_pkg::RULE_CNT_W;
  localparam int LCW = $clog2(LOG_DEPTH + 1);
  localparam logic [RCW-1:0] SLOTS = RCW'(RULE_SLOTS);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state;

  // configuration
  logic log_en;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == eftl_pkg::REG_LOG_EN) ? {31'd0, log_en} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_en <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == eftl_pkg::REG_LOG_EN)) begin
      log_en <= pwdata[0];
    end
  end

  // captured command word
  eftl_pkg::kind_t kind;
  logic [7:0]      ev_code;
  logic            ev_ok;
  logic [15:0]     ev_pid;
  eftl_pkg::rule_t new_rule;
  logic [3:0]      del_idx;

  logic [RCW-1:0] rules_held;
  logic           commit;
  logic           out_valid;

  assign cmd.ready = state == ST_IDLE;
  assign commit    = (state == ST_EXEC) && (!out_valid || rsp.ready);

  // rule cell row
  eftl_pkg::rule_ctl_t rctl;
  eftl_pkg::rule_t     rules [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] hits;
  logic add_err;
  logic del_err;
  logic hit;

  assign add_err = rules_held >= SLOTS;
  assign del_err = {{(RCW-4){1'b0}}, del_idx} >= rules_held;
  assign hit     = (rules_held == '0) || (|hits);

  assign rctl.add      = kind == eftl_pkg::KIND_ADD && !add_err;
  assign rctl.del      = kind == eftl_pkg::KIND_DEL && !del_err;
  assign rctl.count    = rules_held;
  assign rctl.del_idx  = {{(RCW-4){1'b0}}, del_idx};
  assign rctl.new_rule = new_rule;
  assign rctl.ev_code  = ev_code;
  assign rctl.ev_ok    = ev_ok;

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    eftl_pkg::rule_t nbr;
    if (g == RULE_SLOTS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = rules[g+1];
    end
    eftl_rule_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .commit (commit),
      .ctl    (rctl),
      .nbr    (nbr),
      .rule   (rules[g]),
      .hit    (hits[g])
    );
  end

  // log ring
  eftl_pkg::ring_ctl_t lctl;
  eftl_pkg::rec_t      rd_rec;
  logic                log_empty;
  logic [LCW-1:0]      log_count_next;
  logic                do_push;
  logic                do_pop;
  logic [31:0]         count_wide;

  assign do_push   = kind == eftl_pkg::KIND_LOG && log_en && hit;
  assign do_pop    = kind == eftl_pkg::KIND_READ && !log_empty;
  assign lctl.push = commit && do_push;
  assign lctl.pop  = commit && do_pop;
  assign lctl.code = ev_code;
  assign lctl.ok   = ev_ok;
  assign lctl.pid  = ev_pid;

  eftl_log_ring #(.LOG_DEPTH(LOG_DEPTH)) u_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lctl),
    .rd_rec     (rd_rec),
    .empty      (log_empty),
    .count_next (log_count_next)
  );

  assign count_wide = 32'(log_count_next);

  // response register
  logic        res_status;
  logic [3:0]  res_slot;
  logic        res_logged;
  eftl_pkg::rec_t res_rec;
  logic [31:0] res_serial;
  logic [6:0]  res_count;

  logic        status_next;
  logic [3:0]  slot_next;
  eftl_pkg::rec_t rec_next;
  logic [31:0] serial_next;

  always_comb begin
    status_next = 1'b0;
    slot_next   = 4'd0;
    rec_next    = '0;
    serial_next = 32'd0;
    unique case (kind)
      eftl_pkg::KIND_LOG:  status_next = 1'b0;
      eftl_pkg::KIND_ADD: begin
        status_next = add_err;
        slot_next   = add_err ? 4'd0 : rules_held[3:0];
      end
      eftl_pkg::KIND_DEL:  status_next = del_err;
      eftl_pkg::KIND_READ: begin
        status_next = log_empty;
        rec_next    = log_empty ? '0 : rd_rec;
        serial_next = log_empty ? 32'd0 : rd_rec.id + 32'd1;
      end
      default:             status_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      rules_held <= '0;
    end else begin
      if (rsp.ready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            state    <= ST_EXEC;
            kind     <= eftl_pkg::kind_t'(cmd.kind);
            ev_code  <= cmd.event_type;
            ev_ok    <= cmd.success;
            ev_pid   <= cmd.pid;
            new_rule <= '{enabled: cmd.rule_enabled, code: cmd.rule_type,
                          filter: cmd.rule_filter};
            del_idx  <= cmd.rule_index;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state      <= ST_IDLE;
            out_valid  <= 1'b1;
            res_status <= status_next;
            res_slot   <= slot_next;
            res_logged <= do_push;
            res_rec    <= rec_next;
            res_serial <= serial_next;
            res_count  <= count_wide[6:0];
            if (rctl.add) begin
              rules_held <= rules_held + 1'b1;
            end else if (rctl.del) begin
              rules_held <= rules_held - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = res_status;
  assign rsp.rule_slot    = res_slot;
  assign rsp.logged       = res_logged;
  assign rsp.rec_id       = res_rec.id;
  assign rsp.rec_serial   = res_serial;
  assign rsp.rec_type     = res_rec.code;
  assign rsp.rec_success  = res_rec.ok;
  assign rsp.rec_pid      = res_rec.pid;
  assign rsp.record_count = res_count;

endmodule
